// ----- hdl/ldq_pkg.sv -----
// ----------------------------------------------------------------------------
// ldq_pkg
// Shared types, codes and fp32 helper functions for the weight dequantizer.
// ----------------------------------------------------------------------------
package ldq_pkg;

  localparam int unsigned PipeDepth = 12;

  typedef enum logic [1:0] {
    FMT_INT4  = 2'd0,
    FMT_NVFP4 = 2'd1,
    FMT_FP8   = 2'd2,
    FMT_RSVD  = 2'd3
  } fmt_e;

  typedef enum logic [2:0] {
    CFG_FORMAT_KIND  = 3'd0,
    CFG_GLOBAL_SCALE = 3'd1,
    CFG_ROW_SCALE_EN = 3'd2,
    CFG_ZERO_EN      = 3'd3,
    CFG_OUT_FORMAT   = 3'd4
  } cfg_idx_e;

  localparam logic [31:0] F32Qnan    = 32'h7FC0_0000;
  localparam logic [31:0] F32NegZero = 32'h8000_0000;
  localparam logic [31:0] F32One     = 32'h3F80_0000;

  // leading zero count, 32 when x is zero
  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i] && !found) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] e4m3_to_f32(input logic [7:0] c);
    logic [3:0]  ex;
    logic [2:0]  mn;
    logic [30:0] mag;
    ex = c[6:3];
    mn = c[2:0];
    if (ex != 4'd0) begin
      mag = {({4'b0, ex} + 8'd120), mn, 20'b0};
    end else begin
      case (mn)
        3'd0:       mag = 31'b0;
        3'd1:       mag = {8'd118, 23'b0};
        3'd2, 3'd3: mag = {8'd119, mn[0], 22'b0};
        default:    mag = {8'd120, mn[1:0], 21'b0};
      endcase
    end
    return {c[7], mag};
  endfunction

  function automatic logic [31:0] int4_to_f32(input logic [3:0] q);
    logic [4:0]  p;
    logic [23:0] m24;
    p = q[3] ? 5'd3 : q[2] ? 5'd2 : q[1] ? 5'd1 : 5'd0;
    m24 = {20'b0, q} << (5'd23 - p);
    if (q == 4'd0) begin
      return 32'b0;
    end
    return {1'b0, 8'd127 + {3'b0, p}, m24[22:0]};
  endfunction

  function automatic logic [31:0] e2m1_to_f32(input logic [3:0] n);
    logic [30:0] mag;
    case (n[2:0])
      3'd0:    mag = 31'h0000_0000;
      3'd1:    mag = 31'h3F00_0000;
      3'd2:    mag = 31'h3F80_0000;
      3'd3:    mag = 31'h3FC0_0000;
      3'd4:    mag = 31'h4000_0000;
      3'd5:    mag = 31'h4040_0000;
      3'd6:    mag = 31'h4080_0000;
      default: mag = 31'h40C0_0000;
    endcase
    return {n[3], mag};
  endfunction

  function automatic logic [15:0] f32_to_bf16(input logic [31:0] b);
    logic [31:0] t;
    t = b + 32'h0000_7FFF + {31'b0, b[16]};
    if (b[30:0] > 31'h7F80_0000) begin
      return 16'h7FC0;
    end
    return t[31:16];
  endfunction

  function automatic logic [15:0] f32_to_fp16(input logic [31:0] b);
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [15:0] qn;
    logic [7:0]  sh;
    logic [31:0] mm;
    logic [31:0] qs;
    logic [31:0] rem;
    logic [31:0] half;
    sgn  = b[31];
    e    = b[30:23];
    m    = b[22:0];
    qn   = {1'b0, e[4:0] - 5'd16, m[22:13]};
    sh   = 8'd126 - e;
    mm   = {8'b0, 1'b1, m};
    qs   = mm >> sh[4:0];
    rem  = mm & ~(32'hFFFF_FFFF << sh[4:0]);
    half = 32'h1 << (sh[4:0] - 5'd1);
    if (e == 8'hFF) begin
      return (m != 23'b0) ? 16'h7E00 : {sgn, 15'h7C00};
    end else if (e == 8'd0) begin
      return {sgn, 15'b0};
    end else if (e >= 8'd143) begin
      return {sgn, 15'h7C00};
    end else if (e >= 8'd113) begin
      if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && qn[0])) begin
        qn = qn + 16'd1;
      end
      return {sgn, qn[14:0]};
    end else if (sh > 8'd31) begin
      return {sgn, 15'b0};
    end
    if (rem > half || (rem == half && qs[0])) begin
      qs = qs + 32'd1;
    end
    return {sgn, qs[14:0]};
  endfunction

endpackage

// ----- hdl/ldq_fmul.sv -----
// ----------------------------------------------------------------------------
// ldq_fmul
// Three-stage fp32 multiplier, round to nearest even, full subnormal support.
// ----------------------------------------------------------------------------
module ldq_fmul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  // stage 1: unpack and pre-normalize
  logic [7:0]         ea, eb;
  logic [23:0]        siga, sigb;
  logic [5:0]         za, zb;
  logic signed [10:0] ean, ebn;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  logic               s1_sgn_q, s1_nan_q, s1_inf_q, s1_zero_q;
  logic [23:0]        s1_siga_q, s1_sigb_q;
  logic signed [10:0] s1_esum_q;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    siga   = {|ea, a_i[22:0]};
    sigb   = {|eb, b_i[22:0]};
    za     = ldq_pkg::lzc32({siga, 8'hFF});
    zb     = ldq_pkg::lzc32({sigb, 8'hFF});
    ean    = $signed({3'b0, (ea == 8'd0) ? 8'd1 : ea}) - $signed({5'b0, za});
    ebn    = $signed({3'b0, (eb == 8'd0) ? 8'd1 : eb}) - $signed({5'b0, zb});
    a_nan  = (ea == 8'hFF) && (a_i[22:0] != 23'b0);
    b_nan  = (eb == 8'hFF) && (b_i[22:0] != 23'b0);
    a_inf  = (ea == 8'hFF) && (a_i[22:0] == 23'b0);
    b_inf  = (eb == 8'hFF) && (b_i[22:0] == 23'b0);
    a_zero = (a_i[30:0] == 31'b0);
    b_zero = (b_i[30:0] == 31'b0);
  end

  always_ff @(posedge clk_i) begin
    s1_sgn_q  <= a_i[31] ^ b_i[31];
    s1_nan_q  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    s1_inf_q  <= a_inf | b_inf;
    s1_zero_q <= a_zero | b_zero;
    s1_siga_q <= siga << za[4:0];
    s1_sigb_q <= sigb << zb[4:0];
    s1_esum_q <= ean + ebn;
  end

  // stage 2: significand product
  logic               s2_sgn_q, s2_nan_q, s2_inf_q, s2_zero_q;
  logic [47:0]        s2_prod_q;
  logic signed [10:0] s2_esum_q;

  always_ff @(posedge clk_i) begin
    s2_sgn_q  <= s1_sgn_q;
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_zero_q <= s1_zero_q;
    s2_prod_q <= s1_siga_q * s1_sigb_q;
    s2_esum_q <= s1_esum_q;
  end

  // stage 3: normalize, denormalize, round, pack
  logic signed [10:0] e, kk;
  logic [5:0]         k;
  logic [47:0]        pn, shifted, lost;
  logic [23:0]        q;
  logic               rnd;
  logic [8:0]         ebase;
  logic [32:0]        sum;
  logic [31:0]        y_d;
  logic [31:0]        y_q;

  always_comb begin
    e       = s2_prod_q[47] ? s2_esum_q - 11'sd126 : s2_esum_q - 11'sd127;
    pn      = s2_prod_q[47] ? s2_prod_q : s2_prod_q << 1;
    kk      = 11'sd1 - e;
    k       = 6'd0;
    if (e < 11'sd1) begin
      k = (kk > 11'sd48) ? 6'd48 : kk[5:0];
    end
    shifted = pn >> k;
    lost    = pn & ~({48{1'b1}} << k);
    q       = shifted[47:24];
    rnd     = shifted[23] & ((|shifted[22:0]) | (|lost) | q[0]);
    ebase   = (e >= 11'sd1) ? 9'(e - 11'sd1) : 9'd0;
    sum     = {1'b0, ebase, 23'b0} + {9'b0, q} + {32'b0, rnd};
    if (s2_nan_q) begin
      y_d = ldq_pkg::F32Qnan;
    end else if (s2_inf_q) begin
      y_d = {s2_sgn_q, 8'hFF, 23'b0};
    end else if (s2_zero_q) begin
      y_d = {s2_sgn_q, 31'b0};
    end else if (sum >= 33'h0_7F80_0000) begin
      y_d = {s2_sgn_q, 8'hFF, 23'b0};
    end else begin
      y_d = {s2_sgn_q, sum[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

// ----- hdl/ldq_fadd.sv -----
// ----------------------------------------------------------------------------
// ldq_fadd
// Three-stage fp32 adder, round to nearest even, full subnormal support.
// ----------------------------------------------------------------------------
module ldq_fadd (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  // stage 1: order by magnitude and align
  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, d;
  logic [26:0] sigb, sigs, al, lost;
  logic        a_nan, b_nan, a_inf, b_inf;

  logic        s1_sgn_q, s1_sub_q, s1_nan_q, s1_inf_q, s1_infs_q;
  logic [7:0]  s1_e_q;
  logic [26:0] s1_sigb_q, s1_sigs_q;

  always_comb begin
    swap  = b_i[30:0] > a_i[30:0];
    big   = swap ? b_i : a_i;
    sml   = swap ? a_i : b_i;
    eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = eb - es;
    sigb  = {|big[30:23], big[22:0], 3'b0};
    sigs  = {|sml[30:23], sml[22:0], 3'b0};
    al    = sigs >> d;
    lost  = sigs & ~({27{1'b1}} << d);
    a_nan = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'b0);
    b_nan = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'b0);
    a_inf = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'b0);
    b_inf = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'b0);
  end

  always_ff @(posedge clk_i) begin
    s1_sgn_q  <= big[31];
    s1_sub_q  <= a_i[31] ^ b_i[31];
    s1_nan_q  <= a_nan | b_nan | (a_inf & b_inf & (a_i[31] ^ b_i[31]));
    s1_inf_q  <= a_inf | b_inf;
    s1_infs_q <= a_inf ? a_i[31] : b_i[31];
    s1_e_q    <= eb;
    s1_sigb_q <= sigb;
    s1_sigs_q <= {al[26:1], al[0] | (|lost)};
  end

  // stage 2: add or subtract, count leading zeros
  logic [27:0] s;
  logic        s2_sgn_q, s2_sub_q, s2_nan_q, s2_inf_q, s2_infs_q;
  logic [7:0]  s2_e_q;
  logic [27:0] s2_sum_q;
  logic [5:0]  s2_z_q;

  always_comb begin
    if (s1_sub_q) begin
      s = {1'b0, s1_sigb_q} - {1'b0, s1_sigs_q};
    end else begin
      s = {1'b0, s1_sigb_q} + {1'b0, s1_sigs_q};
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sgn_q  <= s1_sgn_q;
    s2_sub_q  <= s1_sub_q;
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_infs_q <= s1_infs_q;
    s2_e_q    <= s1_e_q;
    s2_sum_q  <= s;
    s2_z_q    <= ldq_pkg::lzc32({s[26:0], 5'h1F});
  end

  // stage 3: normalize, round, pack
  logic [7:0]  lim, sh;
  logic [26:0] n;
  logic [8:0]  ef;
  logic [8:0]  ebase;
  logic [23:0] q;
  logic        rnd;
  logic [32:0] sum;
  logic [31:0] y_d;
  logic [31:0] y_q;

  always_comb begin
    lim = s2_e_q - 8'd1;
    sh  = ({2'b0, s2_z_q} > lim) ? lim : {2'b0, s2_z_q};
    if (s2_sum_q[27]) begin
      n  = {s2_sum_q[27:2], s2_sum_q[1] | s2_sum_q[0]};
      ef = {1'b0, s2_e_q} + 9'd1;
    end else begin
      n  = s2_sum_q[26:0] << sh;
      ef = {1'b0, s2_e_q} - {1'b0, sh};
    end
    ebase = ef - 9'd1;
    q     = n[26:3];
    rnd   = n[2] & (n[1] | n[0] | q[0]);
    sum   = {1'b0, ebase, 23'b0} + {9'b0, q} + {32'b0, rnd};
    if (s2_nan_q) begin
      y_d = ldq_pkg::F32Qnan;
    end else if (s2_inf_q) begin
      y_d = {s2_infs_q, 8'hFF, 23'b0};
    end else if (s2_sum_q == 28'b0) begin
      y_d = {~s2_sub_q & s2_sgn_q, 31'b0};
    end else if (sum >= 33'h0_7F80_0000) begin
      y_d = {s2_sgn_q, 8'hFF, 23'b0};
    end else begin
      y_d = {s2_sgn_q, sum[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

// ----- hdl/ldq_lane.sv -----
// ----------------------------------------------------------------------------
// ldq_lane
// One dequantization lane: fp32 multiply, fp32 offset add, narrowing to
// bf16 or fp16, with the narrowed value held in an output register.
// ----------------------------------------------------------------------------
module ldq_lane (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] z_i,
  input  logic        fp16_sel_i,
  output logic [15:0] val_o
);

  logic [31:0] prod;
  logic [31:0] sum;
  logic [31:0] z_q [3];
  logic [15:0] val_q;

  ldq_fmul u_mul (
    .clk_i (clk_i),
    .a_i   (a_i),
    .b_i   (b_i),
    .y_o   (prod)
  );

  // offset follows the product through the multiplier
  always_ff @(posedge clk_i) begin
    z_q[0] <= z_i;
    z_q[1] <= z_q[0];
    z_q[2] <= z_q[1];
  end

  ldq_fadd u_add (
    .clk_i (clk_i),
    .a_i   (prod),
    .b_i   (z_q[2]),
    .y_o   (sum)
  );

  always_ff @(posedge clk_i) begin
    val_q <= fp16_sel_i ? ldq_pkg::f32_to_fp16(sum) : ldq_pkg::f32_to_bf16(sum);
  end

  assign val_o = val_q;

endmodule

// ----- hdl/low_precision_weight_dequantizer.sv -----
// ----------------------------------------------------------------------------
// low_precision_weight_dequantizer
// Dequantizes one packed weight byte (fp8 e4m3, nvfp4 or int4) per request
// into bf16 or fp16 values.
// ----------------------------------------------------------------------------
// Takes a new request every clock cycle; busy_o stays low. Each request gives
// exactly one result, strobed on valid_o once it has passed through the input
// register, 3-stage scale multiplier, then two parallel lanes (3-stage
// multiplier, 3-stage adder, narrowing) and the output register. Results
// come out in request order and cannot be held off. Configuration writes
// take effect at once and are meant for when no request is in flight.
module low_precision_weight_dequantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  packed_byte_i,
  input  logic [31:0] group_scale_i,
  input  logic [31:0] group_zero_i,
  input  logic [31:0] row_scale_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        valid_o,
  output logic [15:0] first_value_o,
  output logic [15:0] second_value_o,
  output logic [1:0]  value_count_o
);

  logic [1:0]  format_kind_q;
  logic [31:0] global_scale_q;
  logic        row_scale_en_q;
  logic        zero_en_q;
  logic        out_fmt_q;
  logic [ldq_pkg::PipeDepth-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_kind_q  <= ldq_pkg::FMT_INT4;
      global_scale_q <= ldq_pkg::F32One;
      row_scale_en_q <= 1'b0;
      zero_en_q      <= 1'b0;
      out_fmt_q      <= 1'b0;
      vld_q          <= '0;
    end else begin
      vld_q <= {vld_q[ldq_pkg::PipeDepth-2:0], start_i};
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ldq_pkg::CFG_FORMAT_KIND:  format_kind_q  <= cfg_wdata_i[1:0];
          ldq_pkg::CFG_GLOBAL_SCALE: global_scale_q <= cfg_wdata_i;
          ldq_pkg::CFG_ROW_SCALE_EN: row_scale_en_q <= cfg_wdata_i[0];
          ldq_pkg::CFG_ZERO_EN:      zero_en_q      <= cfg_wdata_i[0];
          ldq_pkg::CFG_OUT_FORMAT:   out_fmt_q      <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  assign busy_o = 1'b0;

  logic is_fp8, is_int4;
  assign is_fp8  = (format_kind_q == ldq_pkg::FMT_FP8);
  assign is_int4 = (format_kind_q == ldq_pkg::FMT_INT4);

  // request register
  logic [7:0]  byte_q;
  logic [31:0] gs_q, gz_q, rs_q;
  logic [31:0] scale;

  always_ff @(posedge clk_i) begin
    byte_q <= packed_byte_i;
    gs_q   <= group_scale_i;
    gz_q   <= group_zero_i;
    rs_q   <= row_scale_i;
  end

  assign scale = row_scale_en_q ? rs_q : global_scale_q;

  // nvfp4 block scale times row or global scale
  logic [31:0] pre_scale;

  ldq_fmul u_pre_mul (
    .clk_i (clk_i),
    .a_i   (ldq_pkg::e4m3_to_f32(gs_q[7:0])),
    .b_i   (scale),
    .y_o   (pre_scale)
  );

  logic [7:0]  byte_d_q [3];
  logic [31:0] gs_d_q   [3];
  logic [31:0] gz_d_q   [3];
  logic [31:0] sc_d_q   [3];

  always_ff @(posedge clk_i) begin
    byte_d_q[0] <= byte_q;
    gs_d_q[0]   <= gs_q;
    gz_d_q[0]   <= gz_q;
    sc_d_q[0]   <= scale;
    for (int i = 1; i < 3; i++) begin
      byte_d_q[i] <= byte_d_q[i-1];
      gs_d_q[i]   <= gs_d_q[i-1];
      gz_d_q[i]   <= gz_d_q[i-1];
      sc_d_q[i]   <= sc_d_q[i-1];
    end
  end

  // lane operands
  logic [3:0]  lo_nib, hi_nib;
  logic [31:0] a0, b0, a1, b1, zoff;

  always_comb begin
    lo_nib = byte_d_q[2][3:0];
    hi_nib = byte_d_q[2][7:4];
    zoff   = (is_int4 && zero_en_q) ? gz_d_q[2] : ldq_pkg::F32NegZero;
    if (is_fp8) begin
      a0 = ldq_pkg::e4m3_to_f32(byte_d_q[2]);
      b0 = sc_d_q[2];
      a1 = 32'b0;
      b1 = 32'b0;
    end else if (is_int4) begin
      a0 = ldq_pkg::int4_to_f32(lo_nib);
      b0 = gs_d_q[2];
      a1 = ldq_pkg::int4_to_f32(hi_nib);
      b1 = gs_d_q[2];
    end else begin
      a0 = ldq_pkg::e2m1_to_f32(lo_nib);
      b0 = pre_scale;
      a1 = ldq_pkg::e2m1_to_f32(hi_nib);
      b1 = pre_scale;
    end
  end

  logic [15:0] lane0_val, lane1_val;

  ldq_lane u_lane0 (
    .clk_i      (clk_i),
    .a_i        (a0),
    .b_i        (b0),
    .z_i        (zoff),
    .fp16_sel_i (out_fmt_q),
    .val_o      (lane0_val)
  );

  ldq_lane u_lane1 (
    .clk_i      (clk_i),
    .a_i        (a1),
    .b_i        (b1),
    .z_i        (zoff),
    .fp16_sel_i (out_fmt_q),
    .val_o      (lane1_val)
  );

  // merge
  logic [15:0] first_q, second_q;
  logic [1:0]  count_q;

  always_ff @(posedge clk_i) begin
    first_q  <= lane0_val;
    second_q <= is_fp8 ? 16'b0 : lane1_val;
    count_q  <= is_fp8 ? 2'd1 : 2'd2;
  end

  assign valid_o        = vld_q[ldq_pkg::PipeDepth-1];
  assign first_value_o  = first_q;
  assign second_value_o = second_q;
  assign value_count_o  = count_q;

endmodule

// ----- bench/low_precision_weight_dequantizer_checker.sv -----
// ----------------------------------------------------------------------------
// low_precision_weight_dequantizer_checker
// Watches the request, configuration and result ports of the dequantizer,
// predicts each result with a bit-exact fp32 model of its own, and
// compares the results in order.
// ----------------------------------------------------------------------------
module low_precision_weight_dequantizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [7:0]  packed_byte_i,
  input  logic [31:0] group_scale_i,
  input  logic [31:0] group_zero_i,
  input  logic [31:0] row_scale_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        valid_i,
  input  logic [15:0] first_value_i,
  input  logic [15:0] second_value_i,
  input  logic [1:0]  value_count_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] second;
    logic [1:0]  count;
  } weights_t;

  localparam logic [31:0] PosInf = 32'h7F80_0000;

  logic [1:0]  fmt_q;
  logic [31:0] gscale_q;
  logic        rowen_q;
  logic        zeroen_q;
  logic        ofmt_q;
  weights_t    expected_weights[$];
  int          fails = 0;

  // round sig * 2^e to binary32, nearest even; sig below 2^62
  function automatic logic [31:0] f32_round(input logic s, input logic [63:0] sig,
                                            input int e);
    int          p;
    int          ex;
    int          sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    longint      t;
    p = 0;
    for (int i = 0; i < 64; i++) if (sig[i]) p = i;
    ex = p + e + 127;
    sh = (ex >= 1) ? p - 23 : -149 - e;
    if (sh >= 63) begin
      q = 64'd0;
    end else if (sh > 0) begin
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end else begin
      q = sig << (-sh);
    end
    if (ex >= 1) t = (longint'(ex - 1) << 23) + longint'(q);
    else t = longint'(q);
    if (t >= longint'(PosInf)) t = longint'(PosInf);
    return {s, t[30:0]};
  endfunction

  function automatic void f32_parts(input logic [31:0] a, output logic [63:0] m,
                                    output int e);
    if (a[30:23] == 8'd0) begin
      m = {41'd0, a[22:0]};
      e = -149;
    end else begin
      m = {40'd0, 1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return a[30:0] > PosInf[30:0];
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return a[30:0] == PosInf[30:0];
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [63:0] ma;
    logic [63:0] mb;
    int          ea;
    int          eb;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return ldq_pkg::F32Qnan;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return ldq_pkg::F32Qnan;
      return {s, PosInf[30:0]};
    end
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
    f32_parts(a, ma, ea);
    f32_parts(b, mb, eb);
    return f32_round(s, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] big;
    logic [63:0] lit;
    int          ex;
    int          ey;
    int          d;
    int          e;
    if (is_nan(a) || is_nan(b)) return ldq_pkg::F32Qnan;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? ldq_pkg::F32Qnan : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (a[30:23] >= b[30:23]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    f32_parts(x, mx, ex);
    f32_parts(y, my, ey);
    d = ex - ey;
    if (d <= 32) begin
      big = mx << d;
      lit = my;
      e = ey;
    end else begin
      // far smaller operand only acts as a sticky bit
      big = mx << 32;
      lit = 64'd1;
      e = ex - 32;
    end
    if (x[31] == y[31]) return f32_round(x[31], big + lit, e);
    if (big == lit) return 32'd0;
    if (big > lit) return f32_round(x[31], big - lit, e);
    return f32_round(y[31], lit - big, e);
  endfunction

  function automatic logic [15:0] f32_to_bf16_bits(input logic [31:0] b);
    logic [31:0] t;
    if (is_nan(b)) return 16'h7FC0;
    t = b + 32'h0000_7FFF + {31'd0, b[16]};
    return t[31:16];
  endfunction

  function automatic logic [15:0] f32_to_fp16_bits(input logic [31:0] b);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    int          he;
    int          sh;
    logic [31:0] mm;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    s = b[31];
    e = b[30:23];
    m = b[22:0];
    he = int'(e) - 112;
    if (e == 8'hFF) return (m != 23'd0) ? 16'h7E00 : {s, 15'h7C00};
    if (e == 8'd0) return {s, 15'd0};
    if (he >= 31) return {s, 15'h7C00};
    if (he >= 1) begin
      q = {17'd0, 5'(he), m[22:13]};
      if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && q[0])) q = q + 32'd1;
      return {s, q[14:0]};
    end
    sh = 126 - int'(e);
    if (sh > 31) return {s, 15'd0};
    mm = {8'd0, 1'b1, m};
    q = mm >> sh;
    rem = mm & ((32'd1 << sh) - 32'd1);
    half = 32'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 32'd1;
    return {s, q[14:0]};
  endfunction

  function automatic logic [31:0] e4m3_value(input logic [7:0] c);
    if (c[6:3] == 4'd0) begin
      if (c[2:0] == 3'd0) return {c[7], 31'd0};
      return f32_round(c[7], {61'd0, c[2:0]}, -9);
    end
    return {c[7], 8'({4'd0, c[6:3]} + 8'd120), c[2:0], 20'd0};
  endfunction

  function automatic logic [31:0] e2m1_value(input logic [3:0] n);
    logic [30:0] mag;
    case (n[2:0])
      3'd0:    mag = 31'h0000_0000;
      3'd1:    mag = 31'h3F00_0000;
      3'd2:    mag = 31'h3F80_0000;
      3'd3:    mag = 31'h3FC0_0000;
      3'd4:    mag = 31'h4000_0000;
      3'd5:    mag = 31'h4040_0000;
      3'd6:    mag = 31'h4080_0000;
      default: mag = 31'h40C0_0000;
    endcase
    return {n[3], mag};
  endfunction

  function automatic logic [15:0] narrow16(input logic [31:0] f);
    return ofmt_q ? f32_to_fp16_bits(f) : f32_to_bf16_bits(f);
  endfunction

  function automatic weights_t dequantize(input logic [7:0] pb, input logic [31:0] gs,
                                          input logic [31:0] gz, input logic [31:0] rs);
    weights_t    r;
    logic [31:0] sc;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] s;
    sc = rowen_q ? rs : gscale_q;
    case (ldq_pkg::fmt_e'(fmt_q))
      ldq_pkg::FMT_FP8: begin
        r.first = narrow16(f32_mul(e4m3_value(pb), sc));
        r.second = 16'd0;
        r.count = 2'd1;
        return r;
      end
      ldq_pkg::FMT_INT4: begin
        w0 = f32_mul((pb[3:0] == 4'd0) ? 32'd0 : f32_round(1'b0, {60'd0, pb[3:0]}, 0), gs);
        w1 = f32_mul((pb[7:4] == 4'd0) ? 32'd0 : f32_round(1'b0, {60'd0, pb[7:4]}, 0), gs);
        if (zeroen_q) begin
          w0 = f32_add(w0, gz);
          w1 = f32_add(w1, gz);
        end
      end
      default: begin
        s = f32_mul(e4m3_value(gs[7:0]), sc);
        w0 = f32_mul(e2m1_value(pb[3:0]), s);
        w1 = f32_mul(e2m1_value(pb[7:4]), s);
      end
    endcase
    r.first = narrow16(w0);
    r.second = narrow16(w1);
    r.count = 2'd2;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fails++;
  endtask

  assign fail_count_o = fails;
  assign pending_o = expected_weights.size();

  always @(posedge clk_i or negedge rst_ni) begin
    weights_t w;
    if (!rst_ni) begin
      fmt_q <= ldq_pkg::FMT_INT4;
      gscale_q <= ldq_pkg::F32One;
      rowen_q <= 1'b0;
      zeroen_q <= 1'b0;
      ofmt_q <= 1'b0;
    end else begin
      if (start_i && !busy_i) expected_weights.push_back(dequantize(packed_byte_i,
          group_scale_i, group_zero_i, row_scale_i));
      if (valid_i) begin
        if (expected_weights.size() == 0) begin
          report_mismatch("unexpected result", first_value_i, 16'd0);
        end else begin
          w = expected_weights.pop_front();
          if (first_value_i !== w.first) report_mismatch("first", first_value_i, w.first);
          if (second_value_i !== w.second)
            report_mismatch("second", second_value_i, w.second);
          if (value_count_i !== w.count)
            report_mismatch("count", {14'd0, value_count_i}, {14'd0, w.count});
        end
      end
      if (cfg_we_i) begin
        case (ldq_pkg::cfg_idx_e'(cfg_idx_i))
          ldq_pkg::CFG_FORMAT_KIND:  fmt_q <= cfg_wdata_i[1:0];
          ldq_pkg::CFG_GLOBAL_SCALE: gscale_q <= cfg_wdata_i;
          ldq_pkg::CFG_ROW_SCALE_EN: rowen_q <= cfg_wdata_i[0];
          ldq_pkg::CFG_ZERO_EN:      zeroen_q <= cfg_wdata_i[0];
          ldq_pkg::CFG_OUT_FORMAT:   ofmt_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- bench/low_precision_weight_dequantizer_test.sv -----
// ----------------------------------------------------------------------------
// low_precision_weight_dequantizer_test
// Drives directed and random weight requests through every format and
// output setting, with random sender idling, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module low_precision_weight_dequantizer_test;

  localparam logic [2:0] CfgIdxUnused = 3'd5;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 143;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [7:0]  packed_byte_i;
  logic [31:0] group_scale_i;
  logic [31:0] group_zero_i;
  logic [31:0] row_scale_i;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        valid_o;
  logic [15:0] first_value_o;
  logic [15:0] second_value_o;
  logic [1:0]  value_count_o;
  int          fail_count;
  int          pending;
  int          idle_pct;
  logic [1:0]  cur_fmt;

  low_precision_weight_dequantizer u_top (.*);

  low_precision_weight_dequantizer_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .packed_byte_i, .group_scale_i,
    .group_zero_i, .row_scale_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .valid_i(valid_o), .first_value_i(first_value_o), .second_value_i(second_value_o),
    .value_count_i(value_count_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] rand_f32();
    logic s;
    s = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return {s, 8'($urandom_range(100, 150)), 23'($urandom)};
      2: return {s, 8'($urandom_range(118, 134)), 23'($urandom)};
      3: return {s, 8'd0, 23'($urandom)};
      4: begin
        case ($urandom_range(0, 7))
          0: return 32'h0000_0000;
          1: return ldq_pkg::F32NegZero;
          2: return 32'h7F80_0000;
          3: return 32'hFF80_0000;
          4: return ldq_pkg::F32Qnan;
          5: return ldq_pkg::F32One;
          6: return 32'h7F7F_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return {s, 8'($urandom_range(120, 130)), 23'($urandom)};
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic setup(input logic [1:0] fmt, input logic [31:0] gsc, input logic rowen,
                       input logic zeroen, input logic ofmt);
    write_reg(ldq_pkg::CFG_FORMAT_KIND, {30'd0, fmt});
    write_reg(ldq_pkg::CFG_GLOBAL_SCALE, gsc);
    write_reg(ldq_pkg::CFG_ROW_SCALE_EN, {31'd0, rowen});
    write_reg(ldq_pkg::CFG_ZERO_EN, {31'd0, zeroen});
    write_reg(ldq_pkg::CFG_OUT_FORMAT, {31'd0, ofmt});
    cur_fmt = fmt;
  endtask

  task automatic issue(input logic [7:0] pb, input logic [31:0] gs, input logic [31:0] gz,
                       input logic [31:0] rs);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i = 1'b1;
    packed_byte_i = pb;
    group_scale_i = gs;
    group_zero_i = gz;
    row_scale_i = rs;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (ldq_pkg::PipeDepth + 4) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] gs;
    rst_ni = 1'b0;
    start_i = 1'b0;
    packed_byte_i = 8'd0;
    group_scale_i = 32'd0;
    group_zero_i = 32'd0;
    row_scale_i = 32'd0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ldq_pkg::CFG_FORMAT_KIND;
    cfg_wdata_i = 32'd0;
    idle_pct = 0;
    cur_fmt = ldq_pkg::FMT_INT4;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: int4, bf16, global scale one
    issue(8'h00, ldq_pkg::F32One, 32'd0, 32'd0);
    issue(8'hFF, ldq_pkg::F32One, 32'd0, 32'd0);
    issue(8'hF0, 32'hC2F6_0000, 32'd0, 32'd0);
    drain();
    write_reg(CfgIdxUnused, 32'hFFFF_FFFF);
    setup(ldq_pkg::FMT_FP8, ldq_pkg::F32One, 1'b0, 1'b0, 1'b1);
    issue(8'h00, 32'd0, 32'd0, 32'd0);
    issue(8'h80, 32'd0, 32'd0, 32'd0);
    issue(8'h7F, 32'd0, 32'd0, 32'd0);
    issue(8'hFF, 32'd0, 32'd0, 32'd0);
    issue(8'h01, 32'd0, 32'd0, 32'd0);
    issue(8'h81, 32'd0, 32'd0, 32'd0);
    drain();
    setup(ldq_pkg::FMT_NVFP4, 32'd0, 1'b1, 1'b0, 1'b0);
    issue(8'h10, 32'hFFFF_FF7E, 32'd0, ldq_pkg::F32One);
    issue(8'h98, 32'h0000_0038, 32'd0, ldq_pkg::F32Qnan);
    issue(8'hF7, 32'h0000_00FF, 32'd0, 32'h7F80_0000);
    issue(8'hE5, 32'h0000_0001, 32'd0, 32'h0000_0001);
    drain();
    setup(ldq_pkg::FMT_RSVD, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
    issue(8'h76, 32'h0000_0044, 32'd0, 32'd0);
    drain();
    setup(ldq_pkg::FMT_INT4, 32'd0, 1'b0, 1'b1, 1'b1);
    issue(8'hFF, 32'h477F_E000, 32'h477F_E000, 32'd0);
    issue(8'h21, 32'h3380_0000, 32'h8000_0000, 32'd0);
    issue(8'h11, 32'h0000_0001, ldq_pkg::F32Qnan, 32'd0);
    issue(8'h1F, ldq_pkg::F32One, 32'hC170_0000, 32'd0);
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 65;
        default: idle_pct = 15;
      endcase
      case (ph)
        0: gs = 32'd0;
        1: gs = 32'hFFFF_FFFF;
        2: gs = ldq_pkg::F32One;
        default: gs = rand_f32();
      endcase
      setup(2'(ph % 4), gs, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            1'(ph / 4 % 2 == 0 ? ph % 2 : $urandom_range(0, 1)));
      for (int n = 0; n < PhaseItems; n++) begin
        gs = rand_f32();
        if (cur_fmt != ldq_pkg::FMT_INT4 && $urandom_range(0, 1)) gs = {$urandom};
        issue(8'($urandom), gs, rand_f32(), rand_f32());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
